>>> src/aabb_pkg.sv
package aabb_pkg;

    localparam int COORD_W   = 32;
    localparam int COEF_W    = 16;
    localparam int ROW_W     = 3 * COEF_W;
    localparam int PROD_W    = COORD_W + COEF_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int COEF_FRAC = 12;
    localparam int ROUND_BIAS = 1 << (COEF_FRAC - 1);
    localparam int NUM_AXES  = 3;
    localparam int NUM_STAGES = 4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic        [ROW_W-1:0]   row_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } stage_ctl_t;

    localparam int QUOT_W = SUM_W - COEF_FRAC;

    // round-half-up already added, drop fraction and clamp to 32 bits
    function automatic coord_t shift_sat(input sum_t s);
        logic signed [QUOT_W-1:0] q;
        logic                     fits;
        coord_t                   r;
        q    = $signed(s[SUM_W-1:COEF_FRAC]);
        fits = (&q[QUOT_W-1:COORD_W-1]) || !(|q[QUOT_W-1:COORD_W-1]);
        if (fits)
        begin
            r = q[COORD_W-1:0];
        end
        else if (q[QUOT_W-1])
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> src/aabb_if.sv
interface aabb_in_if;
    import aabb_pkg::*;

    logic   valid;
    logic   ready;
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    row_t   row_x_linear;
    row_t   row_y_linear;
    row_t   row_z_linear;
    coord_t shift_x;
    coord_t shift_y;
    coord_t shift_z;

    modport source (
        output valid, min_x, min_y, min_z, max_x, max_y, max_z,
               row_x_linear, row_y_linear, row_z_linear, shift_x, shift_y, shift_z,
        input  ready
    );

    modport sink (
        input  valid, min_x, min_y, min_z, max_x, max_y, max_z,
               row_x_linear, row_y_linear, row_z_linear, shift_x, shift_y, shift_z,
        output ready
    );
endinterface

interface aabb_out_if;
    import aabb_pkg::*;

    logic   valid;
    logic   ready;
    coord_t world_min_x;
    coord_t world_min_y;
    coord_t world_min_z;
    coord_t world_max_x;
    coord_t world_max_y;
    coord_t world_max_z;

    modport source (
        output valid, world_min_x, world_min_y, world_min_z,
               world_max_x, world_max_y, world_max_z,
        input  ready
    );

    modport sink (
        input  valid, world_min_x, world_min_y, world_min_z,
               world_max_x, world_max_y, world_max_z,
        output ready
    );
endinterface

>>> src/aabb_axis.sv
module aabb_axis (
    input  logic                clk,
    input  aabb_pkg::stage_ctl_t ctl,
    input  aabb_pkg::coord_t    lo [aabb_pkg::NUM_AXES],
    input  aabb_pkg::coord_t    hi [aabb_pkg::NUM_AXES],
    input  aabb_pkg::row_t      row,
    input  aabb_pkg::coord_t    shift,
    output aabb_pkg::coord_t    wmin,
    output aabb_pkg::coord_t    wmax
);
    import aabb_pkg::*;

    prod_t  prod_lo_reg [NUM_AXES];
    prod_t  prod_hi_reg [NUM_AXES];
    coord_t shift_s0_reg;
    prod_t  term_min_reg [NUM_AXES];
    prod_t  term_max_reg [NUM_AXES];
    coord_t shift_s1_reg;
    sum_t   sum_min_reg;
    sum_t   sum_max_reg;
    coord_t wmin_reg;
    coord_t wmax_reg;

    sum_t   sum_min_next;
    sum_t   sum_max_next;
    sum_t   offset;

    // products of each coefficient with both box extremes
    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                prod_lo_reg[j] <= prod_t'($signed(row[j*COEF_W +: COEF_W])) * prod_t'(lo[j]);
                prod_hi_reg[j] <= prod_t'($signed(row[j*COEF_W +: COEF_W])) * prod_t'(hi[j]);
            end
            shift_s0_reg <= shift;
        end
    end

    // the extreme corner is picked per term, sums stay separable
    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                if (prod_lo_reg[j] < prod_hi_reg[j])
                begin
                    term_min_reg[j] <= prod_lo_reg[j];
                    term_max_reg[j] <= prod_hi_reg[j];
                end
                else
                begin
                    term_min_reg[j] <= prod_hi_reg[j];
                    term_max_reg[j] <= prod_lo_reg[j];
                end
            end
            shift_s1_reg <= shift_s0_reg;
        end
    end

    always_comb
    begin
        offset       = (sum_t'(shift_s1_reg) <<< COEF_FRAC) + sum_t'(ROUND_BIAS);
        sum_min_next = sum_t'(term_min_reg[0]) + sum_t'(term_min_reg[1])
                     + sum_t'(term_min_reg[2]) + offset;
        sum_max_next = sum_t'(term_max_reg[0]) + sum_t'(term_max_reg[1])
                     + sum_t'(term_max_reg[2]) + offset;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            sum_min_reg <= sum_min_next;
            sum_max_reg <= sum_max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            wmin_reg <= shift_sat(sum_min_reg);
            wmax_reg <= shift_sat(sum_max_reg);
        end
    end

    assign wmin = wmin_reg;
    assign wmax = wmax_reg;

endmodule

>>> src/aabb_pipe_ctrl.sv
module aabb_pipe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aabb_pkg::stage_ctl_t ctl
);
    import aabb_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   stage_ready;

    // a stage takes new data when empty or when its contents move on
    always_comb
    begin
        stage_ready[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (k == 0)
            begin
                valid_next[k] = stage_ready[k] ? in_valid : valid_reg[k];
            end
            else
            begin
                valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
            end
        end
        ctl.load = stage_ready[NUM_STAGES-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

>>> src/aabb_affine_transform.sv
// stages from request accept to result valid: multiply, extreme select, sum, round and
//   saturate; a result also waits while the sink is not ready
// throughput: one request per cycle; each stage holds while the one after it is full
// reset: asynchronous active-low rst_n empties all stages; data registers are not reset
module aabb_affine_transform (
    input  logic       clk,
    input  logic       rst_n,
    aabb_in_if.sink    box,
    aabb_out_if.source world
);
    import aabb_pkg::*;

    stage_ctl_t ctl;
    coord_t     lo [NUM_AXES];
    coord_t     hi [NUM_AXES];

    assign lo[0] = box.min_x;
    assign lo[1] = box.min_y;
    assign lo[2] = box.min_z;
    assign hi[0] = box.max_x;
    assign hi[1] = box.max_y;
    assign hi[2] = box.max_z;

    aabb_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (box.valid),
        .in_ready  (box.ready),
        .out_valid (world.valid),
        .out_ready (world.ready),
        .ctl       (ctl)
    );

    aabb_axis u_axis_x (
        .clk   (clk),
        .ctl   (ctl),
        .lo    (lo),
        .hi    (hi),
        .row   (box.row_x_linear),
        .shift (box.shift_x),
        .wmin  (world.world_min_x),
        .wmax  (world.world_max_x)
    );

    aabb_axis u_axis_y (
        .clk   (clk),
        .ctl   (ctl),
        .lo    (lo),
        .hi    (hi),
        .row   (box.row_y_linear),
        .shift (box.shift_y),
        .wmin  (world.world_min_y),
        .wmax  (world.world_max_y)
    );

    aabb_axis u_axis_z (
        .clk   (clk),
        .ctl   (ctl),
        .lo    (lo),
        .hi    (hi),
        .row   (box.row_z_linear),
        .shift (box.shift_z),
        .wmin  (world.world_min_z),
        .wmax  (world.world_max_z)
    );

endmodule

>>> src/aabb_affine_transform_chk.sv
module aabb_affine_transform_chk (
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input aabb_pkg::coord_t world_min_x,
    input aabb_pkg::coord_t world_min_y,
    input aabb_pkg::coord_t world_min_z,
    input aabb_pkg::coord_t world_max_x,
    input aabb_pkg::coord_t world_max_y,
    input aabb_pkg::coord_t world_max_z
);
    import aabb_pkg::*;

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("empty pipeline refuses request");

    a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("request stalled while sink is ready");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (world_min_x <= world_max_x) && (world_min_y <= world_max_y)
                      && (world_min_z <= world_max_z))
        else $error("world box inverted");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(world_min_x)
                                    && $stable(world_max_z))
        else $error("stalled result changed");

endmodule

bind aabb_affine_transform aabb_affine_transform_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (box.ready),
    .out_valid   (world.valid),
    .out_ready   (world.ready),
    .world_min_x (world.world_min_x),
    .world_min_y (world.world_min_y),
    .world_min_z (world.world_min_z),
    .world_max_x (world.world_max_x),
    .world_max_y (world.world_max_y),
    .world_max_z (world.world_max_z)
);

>>> bench/aabb_box_pkg.sv
package aabb_box_pkg;
    import aabb_pkg::*;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
        row_t   row_x_linear;
        row_t   row_y_linear;
        row_t   row_z_linear;
        coord_t shift_x;
        coord_t shift_y;
        coord_t shift_z;
    } box_req_t;

    typedef struct packed {
        coord_t world_min_x;
        coord_t world_min_y;
        coord_t world_min_z;
        coord_t world_max_x;
        coord_t world_max_y;
        coord_t world_max_z;
    } world_box_t;

    localparam int WORLD_FIELDS = 6;

endpackage

>>> bench/aabb_bound_monitor.sv
module aabb_bound_monitor (
    input  logic clk,
    input  logic rst_n,
    aabb_in_if   box,
    aabb_out_if  world,
    output int   mismatches,
    output int   outstanding
);
    import aabb_pkg::*;
    import aabb_box_pkg::*;

    localparam longint COORD_TOP    = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
    localparam longint COORD_BOTTOM = -(64'sd1 <<< (COORD_W - 1));
    localparam int     REPORT_MAX   = 10;

    world_box_t expected_boxes [$];
    string      field_name [WORLD_FIELDS] = '{"world_min_x", "world_min_y", "world_min_z",
                                              "world_max_x", "world_max_y", "world_max_z"};

    function automatic world_box_t bound_world_box(input box_req_t r);
        coord_t     lo [NUM_AXES];
        coord_t     hi [NUM_AXES];
        coord_t     shift [NUM_AXES];
        row_t       row [NUM_AXES];
        coord_t     wmin [NUM_AXES];
        coord_t     wmax [NUM_AXES];
        longint     pt [NUM_AXES];
        longint     acc;
        coord_t     v;
        world_box_t w;
        lo    = '{r.min_x, r.min_y, r.min_z};
        hi    = '{r.max_x, r.max_y, r.max_z};
        row   = '{r.row_x_linear, r.row_y_linear, r.row_z_linear};
        shift = '{r.shift_x, r.shift_y, r.shift_z};
        for (int c = 0; c < 8; c++)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                pt[k] = c[k] ? longint'(hi[k]) : longint'(lo[k]);
            end
            for (int a = 0; a < NUM_AXES; a++)
            begin
                acc = longint'(shift[a]) * (64'sd1 <<< COEF_FRAC);
                for (int k = 0; k < NUM_AXES; k++)
                begin
                    acc += longint'($signed(row[a][k*COEF_W +: COEF_W])) * pt[k];
                end
                // round half up, then floor
                acc = (acc + ROUND_BIAS) >>> COEF_FRAC;
                if (acc > COORD_TOP)
                begin
                    acc = COORD_TOP;
                end
                if (acc < COORD_BOTTOM)
                begin
                    acc = COORD_BOTTOM;
                end
                v = coord_t'(acc);
                if (c == 0 || v < wmin[a])
                begin
                    wmin[a] = v;
                end
                if (c == 0 || v > wmax[a])
                begin
                    wmax[a] = v;
                end
            end
        end
        w = '{wmin[0], wmin[1], wmin[2], wmax[0], wmax[1], wmax[2]};
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        world_box_t want;
        world_box_t got;
        coord_t     w_field;
        coord_t     g_field;
        if (!rst_n)
        begin
            expected_boxes.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (box.valid && box.ready)
            begin
                expected_boxes.push_back(bound_world_box('{box.min_x, box.min_y, box.min_z,
                    box.max_x, box.max_y, box.max_z, box.row_x_linear, box.row_y_linear,
                    box.row_z_linear, box.shift_x, box.shift_y, box.shift_z}));
            end
            if (world.valid && world.ready)
            begin
                got = '{world.world_min_x, world.world_min_y, world.world_min_z,
                        world.world_max_x, world.world_max_y, world.world_max_z};
                if (expected_boxes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("unexpected world box %h with no request pending", got);
                    end
                end
                else
                begin
                    want = expected_boxes.pop_front();
                    for (int f = 0; f < WORLD_FIELDS; f++)
                    begin
                        w_field = want[COORD_W*(WORLD_FIELDS-1-f) +: COORD_W];
                        g_field = got[COORD_W*(WORLD_FIELDS-1-f) +: COORD_W];
                        if (w_field !== g_field)
                        begin
                            mismatches++;
                            if (mismatches <= REPORT_MAX)
                            begin
                                $display("mismatch on %s: expected %h, got %h",
                                         field_name[f], w_field, g_field);
                            end
                        end
                    end
                end
            end
            outstanding = expected_boxes.size();
        end
    end

endmodule

>>> bench/tb.sv
module tb;
    import aabb_pkg::*;
    import aabb_box_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 208;
    localparam int NUM_PHASES      = 4;
    localparam int TAIL_CYCLES     = 4 * NUM_STAGES;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   cycle_count;
    int   phase_send [NUM_PHASES] = '{0, 62, 0, 25};
    int   phase_recv [NUM_PHASES] = '{0, 0, 62, 25};

    aabb_in_if  box ();
    aabb_out_if world ();

    aabb_affine_transform dut (
        .clk   (clk),
        .rst_n (rst_n),
        .box   (box),
        .world (world)
    );

    aabb_bound_monitor monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .box         (box),
        .world       (world),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic coord_t pick_coord();
        case ($urandom_range(5))
            0, 1:    return coord_t'($urandom);
            2:       return coord_t'(int'($urandom_range(2097151)) - 1048576);
            3:
            begin
                case ($urandom_range(4))
                    0:       return coord_t'(32'h8000_0000);
                    1:       return coord_t'(32'h7fff_ffff);
                    2:       return coord_t'(32'h0);
                    3:       return coord_t'(32'hffff_ffff);
                    default: return coord_t'(32'h1);
                endcase
            end
            default: return coord_t'($signed($urandom) >>> $urandom_range(31));
        endcase
    endfunction

    function automatic coef_t pick_coef();
        case ($urandom_range(6))
            0, 1:    return coef_t'($urandom);
            2:       return coef_t'(16'h1000);
            3:       return coef_t'(16'hf000);
            4:       return coef_t'(16'h0);
            5:       return $urandom_range(1) ? coef_t'(16'h7fff) : coef_t'(16'h8000);
            default: return coef_t'(int'($urandom_range(1023)) - 512);
        endcase
    endfunction

    function automatic box_req_t random_box();
        box_req_t r;
        coord_t   t;
        r.min_x = pick_coord();
        r.min_y = pick_coord();
        r.min_z = pick_coord();
        r.max_x = pick_coord();
        r.max_y = pick_coord();
        r.max_z = pick_coord();
        // mostly well-ordered boxes, some inverted
        if ($urandom_range(3) != 0)
        begin
            if (r.min_x > r.max_x)
            begin
                t = r.min_x; r.min_x = r.max_x; r.max_x = t;
            end
            if (r.min_y > r.max_y)
            begin
                t = r.min_y; r.min_y = r.max_y; r.max_y = t;
            end
            if (r.min_z > r.max_z)
            begin
                t = r.min_z; r.min_z = r.max_z; r.max_z = t;
            end
        end
        r.row_x_linear = {pick_coef(), pick_coef(), pick_coef()};
        r.row_y_linear = {pick_coef(), pick_coef(), pick_coef()};
        r.row_z_linear = {pick_coef(), pick_coef(), pick_coef()};
        r.shift_x = pick_coord();
        r.shift_y = pick_coord();
        r.shift_z = pick_coord();
        return r;
    endfunction

    function automatic box_req_t uniform_box(input coord_t lo, input coord_t hi,
                                             input row_t row, input coord_t shift);
        box_req_t r;
        r = '{lo, lo, lo, hi, hi, hi, row, row, row, shift, shift, shift};
        return r;
    endfunction

    task automatic send_box(input box_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            box.valid <= 1'b0;
            @(negedge clk);
        end
        box.valid        <= 1'b1;
        box.min_x        <= r.min_x;
        box.min_y        <= r.min_y;
        box.min_z        <= r.min_z;
        box.max_x        <= r.max_x;
        box.max_y        <= r.max_y;
        box.max_z        <= r.max_z;
        box.row_x_linear <= r.row_x_linear;
        box.row_y_linear <= r.row_y_linear;
        box.row_z_linear <= r.row_z_linear;
        box.shift_x      <= r.shift_x;
        box.shift_y      <= r.shift_y;
        box.shift_z      <= r.shift_z;
        do
            @(posedge clk);
        while (!box.ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        box.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        world.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            world.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL aabb_affine_transform");
        $finish;
    end

    initial
    begin
        box_req_t directed [$];
        box_req_t r;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        box.valid      = 1'b0;
        {box.min_x, box.min_y, box.min_z, box.max_x, box.max_y, box.max_z} = '0;
        {box.row_x_linear, box.row_y_linear, box.row_z_linear} = '0;
        {box.shift_x, box.shift_y, box.shift_z} = '0;

        // all zero, identity, shifted identity, inverted and point boxes
        directed.push_back('0);
        r = uniform_box(32'hffff_0000, 32'h0002_0000, '0, '0);
        r.row_x_linear = 48'h0000_0000_1000;
        r.row_y_linear = 48'h0000_1000_0000;
        r.row_z_linear = 48'h1000_0000_0000;
        directed.push_back(r);
        r.shift_x = 32'h0003_8000;
        r.shift_y = 32'hfffc_8000;
        r.shift_z = 32'h0000_0001;
        directed.push_back(r);
        r.min_x = 32'h0005_0000; r.max_x = 32'hfffb_0000;
        r.min_y = 32'h0001_0000; r.max_y = 32'hffff_0000;
        r.min_z = 32'h7fff_ffff; r.max_z = 32'h8000_0000;
        directed.push_back(r);
        directed.push_back(uniform_box(32'h1234_5678, 32'h1234_5678,
                                       48'h0800_f000_1000, 32'h0000_0100));
        // field extremes and saturation both ways
        directed.push_back(uniform_box(32'h8000_0000, 32'h7fff_ffff,
                                       48'h7fff_7fff_7fff, 32'h7fff_ffff));
        directed.push_back(uniform_box(32'h8000_0000, 32'h7fff_ffff,
                                       48'h8000_8000_8000, 32'h8000_0000));
        directed.push_back(uniform_box(32'h8000_0000, 32'h8000_0000,
                                       48'h8000_8000_8000, 32'h7fff_ffff));
        directed.push_back(uniform_box(32'h7fff_ffff, 32'h7fff_ffff,
                                       48'h7fff_8000_0001, 32'h8000_0000));
        directed.push_back(uniform_box(32'h0, 32'h0, '0, 32'h8000_0000));
        directed.push_back(uniform_box(32'h0, 32'h0, '0, 32'h7fff_ffff));
        // rounding ties and near ties
        directed.push_back(uniform_box(32'hffff_ffff, 32'h0000_0001,
                                       48'h0000_0000_0800, 32'h0));
        directed.push_back(uniform_box(32'hffff_ffff, 32'h0000_0001,
                                       48'h0800_0800_0800, 32'h0));
        directed.push_back(uniform_box(32'hffff_fffd, 32'h0000_0003,
                                       48'h07ff_0801_f7ff, 32'h0));
        // all ones and alternating bit patterns
        directed.push_back(uniform_box(32'hffff_ffff, 32'hffff_ffff,
                                       48'hffff_ffff_ffff, 32'hffff_ffff));
        directed.push_back(uniform_box(32'haaaa_aaaa, 32'h5555_5555,
                                       48'h5555_aaaa_5555, 32'haaaa_aaaa));
        directed.push_back(uniform_box(32'h5555_5555, 32'haaaa_aaaa,
                                       48'haaaa_5555_aaaa, 32'h5555_5555));
        directed.push_back(uniform_box(32'hc000_0000, 32'h3fff_ffff,
                                       48'h7fff_8000_7fff, 32'hffff_8000));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            send_box(directed[i]);
        end
        // sender holds off until the pipe is empty
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            repeat (ITEMS_PER_PHASE)
            begin
                send_box(random_box());
            end
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("PASS aabb_affine_transform");
        end
        else
        begin
            $display("FAIL aabb_affine_transform");
        end
        $finish;
    end

endmodule

>>> sim.f
src/aabb_pkg.sv
src/aabb_if.sv
src/aabb_axis.sv
src/aabb_pipe_ctrl.sv
src/aabb_affine_transform.sv
src/aabb_affine_transform_chk.sv
bench/aabb_box_pkg.sv
bench/aabb_bound_monitor.sv
bench/tb.sv
